// File: rtl/aarm_pkg.sv
// ----------------------------------------------------------------------------
// aarm_pkg
// Types, fixed constants and the arctan table for the axis-angle rotation
// matrix pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package aarm_pkg;

  localparam int unsigned SQRT_CELLS   = 31;
  localparam int unsigned CORDIC_CELLS = 24;
  localparam int unsigned DIV_CELLS    = 31;
  // input reg, prep, sqrt, divide, unit vector, products, terms, output
  localparam int unsigned PIPE_DEPTH   = 2 + SQRT_CELLS + DIV_CELLS + 4;
  localparam int unsigned CS_DELAY     = SQRT_CELLS + DIV_CELLS - CORDIC_CELLS - 1;
  localparam int unsigned SIDE_DELAY   = SQRT_CELLS + DIV_CELLS + 1;

  localparam logic signed [34:0] Q30_PI      = 35'sd3373259426;
  localparam logic signed [34:0] Q30_HALF_PI = 35'sd1686629713;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [33:0] Q30_ONE     = 34'sd1073741824;

  typedef struct packed {
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic signed [15:0] angle;
  } req_t;

  typedef struct packed {
    logic signed [15:0] c0_r0;
    logic signed [15:0] c0_r1;
    logic signed [15:0] c0_r2;
    logic signed [15:0] c1_r0;
    logic signed [15:0] c1_r1;
    logic signed [15:0] c1_r2;
    logic signed [15:0] c2_r0;
    logic signed [15:0] c2_r1;
    logic signed [15:0] c2_r2;
    logic               zero_axis;
  } res_t;

  typedef struct packed {
    logic [61:0] n;
    logic [61:0] res;
  } sqrt_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [34:0] th;
  } cordic_t;

  typedef struct packed {
    logic [2:0][59:0] rem;
    logic [2:0][30:0] q;
    logic [31:0]      r;
  } div_t;

  typedef struct packed {
    logic [2:0][15:0] mag;
    logic [2:0]       neg;
    logic             zero;
  } side_t;

  typedef struct packed {
    logic signed [31:0] c;
    logic signed [31:0] s;
  } cs_t;

  function automatic logic signed [34:0] atan_q30(input int unsigned idx);
    logic signed [34:0] a;
    unique case (idx)
      0:  a = 35'sd843314856;
      1:  a = 35'sd497837829;
      2:  a = 35'sd263043836;
      3:  a = 35'sd133525158;
      4:  a = 35'sd67021686;
      5:  a = 35'sd33543515;
      6:  a = 35'sd16775850;
      7:  a = 35'sd8388437;
      8:  a = 35'sd4194282;
      9:  a = 35'sd2097149;
      10: a = 35'sd1048575;
      11: a = 35'sd524287;
      12: a = 35'sd262143;
      13: a = 35'sd131071;
      14: a = 35'sd65535;
      15: a = 35'sd32767;
      16: a = 35'sd16383;
      17: a = 35'sd8191;
      18: a = 35'sd4095;
      19: a = 35'sd2047;
      20: a = 35'sd1023;
      21: a = 35'sd511;
      22: a = 35'sd255;
      23: a = 35'sd127;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// File: rtl/axis_angle_rotation_matrix.sv
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix
// Rotation matrix from a raw axis and an angle, Rodrigues form, fixed point.
// ----------------------------------------------------------------------------
// Fully pipelined: a request is taken in every cycle (busy_o stays low) and
// its matrix appears on res_o with done_o after the input, prep, square-root,
// divider, unit-vector, product, term and output registers; 31 square-root
// cells and 31 divider cells (one result bit each) normalise the axis, and the
// 24 CORDIC cells run alongside the square root. Results cannot be held off:
// each is shown for one cycle only.
`default_nettype none

module axis_angle_rotation_matrix #(
  parameter int unsigned OUT_FRAC_BITS = 14
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  output logic                busy_o,
  input  wire aarm_pkg::req_t req_i,
  output logic                done_o,
  output aarm_pkg::res_t      res_o
);
  import aarm_pkg::*;

  localparam int unsigned SH         = 30 - OUT_FRAC_BITS;
  localparam logic signed [35:0] ONE = 36'sd1 <<< OUT_FRAC_BITS;
  localparam logic signed [35:0] RND = (36'sd1 <<< SH) >>> 1;
  localparam logic signed [64:0] HALF30 = 65'sd536870912;

  function automatic logic [15:0] to_out(input logic signed [35:0] v);
    logic signed [35:0] o;
    o = (v + RND) >>> SH;
    if (o > ONE) begin
      o = ONE;
    end else if (o < -ONE) begin
      o = -ONE;
    end
    return o[15:0];
  endfunction

  logic [PIPE_DEPTH-1:0] vld_q;
  req_t                  in_q;

  sqrt_t   sq_b_q;
  cordic_t co_b_q;
  side_t   sd_q [SIDE_DELAY];
  cs_t     cs_q [CS_DELAY+1];

  sqrt_t   sq_pipe [SQRT_CELLS+1];
  cordic_t co_pipe [CORDIC_CELLS+1];
  div_t    dv_pipe [DIV_CELLS+1];

  logic signed [31:0] u_q [3];
  logic signed [31:0] c_q, s_q, c_dq, c_eq;
  logic signed [32:0] oc_q, oc_dq;
  logic               zero_q, zero_dq, zero_eq;
  logic signed [31:0] t_q [6];
  logic signed [31:0] sk_q [3], sk_eq [3];
  logic signed [33:0] term_q [6];
  res_t               out_q;

  // request valid along the pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], start_i && !busy_o};
    end
  end

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      in_q <= req_i;
    end
  end

  // prep: squared length, angle folding, magnitudes
  logic signed [31:0] sqx, sqy, sqz;
  logic [31:0]        ssum;
  logic signed [34:0] th0;
  logic               flip;
  logic signed [34:0] th_red;
  side_t              sd_b;

  always_comb begin
    sqx  = 32'(in_q.axis_x * in_q.axis_x);
    sqy  = 32'(in_q.axis_y * in_q.axis_y);
    sqz  = 32'(in_q.axis_z * in_q.axis_z);
    ssum = 32'(sqx) + 32'(sqy) + 32'(sqz);
    th0  = {{2{in_q.angle[15]}}, in_q.angle, 17'd0};
    priority if (th0 > Q30_HALF_PI) begin
      th_red = th0 - Q30_PI;
      flip   = 1'b1;
    end else if (th0 < -Q30_HALF_PI) begin
      th_red = th0 + Q30_PI;
      flip   = 1'b1;
    end else begin
      th_red = th0;
      flip   = 1'b0;
    end
    sd_b.neg    = {in_q.axis_z[15], in_q.axis_y[15], in_q.axis_x[15]};
    sd_b.mag[0] = in_q.axis_x[15] ? 16'(-in_q.axis_x) : 16'(in_q.axis_x);
    sd_b.mag[1] = in_q.axis_y[15] ? 16'(-in_q.axis_y) : 16'(in_q.axis_y);
    sd_b.mag[2] = in_q.axis_z[15] ? 16'(-in_q.axis_z) : 16'(in_q.axis_z);
    sd_b.zero   = (ssum == 32'd0);
  end

  logic flip_q [CORDIC_CELLS+1];

  always_ff @(posedge clk_i) begin
    sq_b_q.n   <= {2'b00, ssum, 28'd0};
    sq_b_q.res <= '0;
    co_b_q.x   <= CORDIC_GAIN;
    co_b_q.y   <= '0;
    co_b_q.th  <= th_red;
    flip_q[0]  <= flip;
    for (int m = 1; m <= CORDIC_CELLS; m++) begin
      flip_q[m] <= flip_q[m-1];
    end
    sd_q[0] <= sd_b;
    for (int m = 1; m < SIDE_DELAY; m++) begin
      sd_q[m] <= sd_q[m-1];
    end
  end

  assign sq_pipe[0] = sq_b_q;
  assign co_pipe[0] = co_b_q;

  for (genvar j = 0; j < SQRT_CELLS; j++) begin : g_sqrt
    aarm_sqrt_cell #(.K(SQRT_CELLS - 1 - j)) u_cell (
      .clk_i (clk_i),
      .sq_i  (sq_pipe[j]),
      .sq_o  (sq_pipe[j+1])
    );
  end

  for (genvar i = 0; i < CORDIC_CELLS; i++) begin : g_cordic
    aarm_cordic_cell #(.IDX(i)) u_cell (
      .clk_i (clk_i),
      .co_i  (co_pipe[i]),
      .co_o  (co_pipe[i+1])
    );
  end

  // undo the half-turn fold and clamp to +/- one
  logic signed [33:0] cx_f, cy_f;
  cs_t                cs_b;

  always_comb begin
    cx_f = flip_q[CORDIC_CELLS] ? -co_pipe[CORDIC_CELLS].x : co_pipe[CORDIC_CELLS].x;
    cy_f = flip_q[CORDIC_CELLS] ? -co_pipe[CORDIC_CELLS].y : co_pipe[CORDIC_CELLS].y;
    priority if (cx_f > Q30_ONE) cs_b.c = 32'(Q30_ONE);
    else if (cx_f < -Q30_ONE)   cs_b.c = 32'(-Q30_ONE);
    else                        cs_b.c = 32'(cx_f);
    priority if (cy_f > Q30_ONE) cs_b.s = 32'(Q30_ONE);
    else if (cy_f < -Q30_ONE)   cs_b.s = 32'(-Q30_ONE);
    else                        cs_b.s = 32'(cy_f);
  end

  always_ff @(posedge clk_i) begin
    cs_q[0] <= cs_b;
    for (int m = 1; m <= CS_DELAY; m++) begin
      cs_q[m] <= cs_q[m-1];
    end
  end

  // divider feed: |v| * 2^44 over the root
  always_comb begin
    dv_pipe[0].r = sq_pipe[SQRT_CELLS].res[31:0];
    for (int l = 0; l < 3; l++) begin
      dv_pipe[0].rem[l] = {sd_q[SQRT_CELLS].mag[l], 44'd0};
      dv_pipe[0].q[l]   = '0;
    end
  end

  for (genvar j = 0; j < DIV_CELLS; j++) begin : g_div
    aarm_div_cell #(.K(DIV_CELLS - 1 - j)) u_cell (
      .clk_i (clk_i),
      .dv_i  (dv_pipe[j]),
      .dv_o  (dv_pipe[j+1])
    );
  end

  // unit vector, sine, cosine
  logic [30:0] qm [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      qm[l] = (dv_pipe[DIV_CELLS].q[l] > 31'd1073741824) ? 31'd1073741824
                                                         : dv_pipe[DIV_CELLS].q[l];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 3; l++) begin
      u_q[l] <= sd_q[SIDE_DELAY-1].neg[l] ? -$signed({1'b0, qm[l]})
                                          : $signed({1'b0, qm[l]});
    end
    c_q    <= cs_q[CS_DELAY].c;
    s_q    <= cs_q[CS_DELAY].s;
    oc_q   <= 33'sd1073741824 - 33'(cs_q[CS_DELAY].c);
    zero_q <= sd_q[SIDE_DELAY-1].zero;
  end

  // pair products and axis-times-sine
  logic signed [63:0] pp [6];
  logic signed [63:0] ps [3];
  localparam int unsigned PA [6] = '{0, 1, 2, 0, 1, 2};
  localparam int unsigned PB [6] = '{0, 1, 2, 1, 2, 0};

  always_comb begin
    for (int p = 0; p < 6; p++) begin
      pp[p] = u_q[PA[p]] * u_q[PB[p]];
    end
    for (int l = 0; l < 3; l++) begin
      ps[l] = u_q[l] * 64'(s_q);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int p = 0; p < 6; p++) begin
      t_q[p] <= 32'((pp[p] + 64'(HALF30)) >>> 30);
    end
    for (int l = 0; l < 3; l++) begin
      sk_q[l] <= 32'((ps[l] + 64'(HALF30)) >>> 30);
    end
    c_dq    <= c_q;
    oc_dq   <= oc_q;
    zero_dq <= zero_q;
  end

  // scale by one minus cosine
  logic signed [64:0] pe [6];

  always_comb begin
    for (int p = 0; p < 6; p++) begin
      pe[p] = 65'(oc_dq) * 65'(t_q[p]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int p = 0; p < 6; p++) begin
      term_q[p] <= 34'((pe[p] + HALF30) >>> 30);
    end
    for (int l = 0; l < 3; l++) begin
      sk_eq[l] <= sk_q[l];
    end
    c_eq    <= c_dq;
    zero_eq <= zero_dq;
  end

  // assemble; terms are xx, yy, zz, xy, yz, zx
  res_t res_d;

  always_comb begin
    if (zero_eq) begin
      res_d.c0_r0     = ONE[15:0];
      res_d.c0_r1     = '0;
      res_d.c0_r2     = '0;
      res_d.c1_r0     = '0;
      res_d.c1_r1     = ONE[15:0];
      res_d.c1_r2     = '0;
      res_d.c2_r0     = '0;
      res_d.c2_r1     = '0;
      res_d.c2_r2     = ONE[15:0];
      res_d.zero_axis = 1'b1;
    end else begin
      res_d.c0_r0     = to_out(36'(term_q[0]) + 36'(c_eq));
      res_d.c0_r1     = to_out(36'(term_q[3]) - 36'(sk_eq[2]));
      res_d.c0_r2     = to_out(36'(term_q[5]) + 36'(sk_eq[1]));
      res_d.c1_r0     = to_out(36'(term_q[3]) + 36'(sk_eq[2]));
      res_d.c1_r1     = to_out(36'(term_q[1]) + 36'(c_eq));
      res_d.c1_r2     = to_out(36'(term_q[4]) - 36'(sk_eq[0]));
      res_d.c2_r0     = to_out(36'(term_q[5]) - 36'(sk_eq[1]));
      res_d.c2_r1     = to_out(36'(term_q[4]) + 36'(sk_eq[0]));
      res_d.c2_r2     = to_out(36'(term_q[2]) + 36'(c_eq));
      res_d.zero_axis = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= res_d;
  end

  assign done_o = vld_q[PIPE_DEPTH-1];
  assign res_o  = out_q;

  a_identity : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.zero_axis |->
      res_o.c0_r0 == ONE[15:0] && res_o.c1_r1 == ONE[15:0] &&
      res_o.c2_r2 == ONE[15:0] && res_o.c0_r1 == 16'd0 && res_o.c1_r2 == 16'd0)
    else $error("zero axis did not give the identity");

  a_diag_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (OUT_FRAC_BITS <= 14) |->
      36'(res_o.c0_r0) <= ONE && 36'(res_o.c0_r0) >= -ONE &&
      36'(res_o.c1_r1) <= ONE && 36'(res_o.c1_r1) >= -ONE &&
      36'(res_o.c2_r2) <= ONE && 36'(res_o.c2_r2) >= -ONE)
    else $error("diagonal entry outside saturation range");

  a_unit_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[PIPE_DEPTH-4] |->
      u_q[0] <= 32'sd1073741824 && u_q[0] >= -32'sd1073741824 &&
      c_q <= 32'sd1073741824 && c_q >= -32'sd1073741824 &&
      s_q <= 32'sd1073741824 && s_q >= -32'sd1073741824)
    else $error("unit vector or sine/cosine out of range");

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##(PIPE_DEPTH) done_o)
    else $error("request did not complete at the fixed latency");

endmodule

`default_nettype wire

// File: rtl/aarm_sqrt_cell.sv
// ----------------------------------------------------------------------------
// aarm_sqrt_cell
// One digit of the integer square root: decides result bit K and passes the
// partial remainder on.
// ----------------------------------------------------------------------------
`default_nettype none

module aarm_sqrt_cell #(
  parameter int unsigned K = 0
) (
  input  wire logic          clk_i,
  input  wire aarm_pkg::sqrt_t sq_i,
  output aarm_pkg::sqrt_t      sq_o
);
  import aarm_pkg::*;

  localparam logic [61:0] BIT = 62'd1 << (2 * K);

  logic [61:0] trial;
  sqrt_t       sq_d, sq_q;

  always_comb begin
    trial = sq_i.res + BIT;
    if (sq_i.n >= trial) begin
      sq_d.n   = sq_i.n - trial;
      sq_d.res = (sq_i.res >> 1) + BIT;
    end else begin
      sq_d.n   = sq_i.n;
      sq_d.res = sq_i.res >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q <= sq_d;
  end

  assign sq_o = sq_q;

endmodule

`default_nettype wire

// File: rtl/aarm_cordic_cell.sv
// ----------------------------------------------------------------------------
// aarm_cordic_cell
// One rotation-mode CORDIC micro-rotation with a fixed shift of IDX.
// ----------------------------------------------------------------------------
`default_nettype none

module aarm_cordic_cell #(
  parameter int unsigned IDX = 0
) (
  input  wire logic            clk_i,
  input  wire aarm_pkg::cordic_t co_i,
  output aarm_pkg::cordic_t      co_o
);
  import aarm_pkg::*;

  localparam logic signed [34:0] ANGLE = atan_q30(IDX);

  logic signed [33:0] dx, dy;
  cordic_t            co_d, co_q;

  always_comb begin
    dx = co_i.y >>> IDX;
    dy = co_i.x >>> IDX;
    if (co_i.th >= 0) begin
      co_d.x  = co_i.x - dx;
      co_d.y  = co_i.y + dy;
      co_d.th = co_i.th - ANGLE;
    end else begin
      co_d.x  = co_i.x + dx;
      co_d.y  = co_i.y - dy;
      co_d.th = co_i.th + ANGLE;
    end
  end

  always_ff @(posedge clk_i) begin
    co_q <= co_d;
  end

  assign co_o = co_q;

endmodule

`default_nettype wire

// File: rtl/aarm_div_cell.sv
// ----------------------------------------------------------------------------
// aarm_div_cell
// One restoring-division step for the three axis lanes: decides quotient
// bit K against the shared divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module aarm_div_cell #(
  parameter int unsigned K = 0
) (
  input  wire logic         clk_i,
  input  wire aarm_pkg::div_t dv_i,
  output aarm_pkg::div_t      dv_o
);
  import aarm_pkg::*;

  logic [61:0] dsh;
  logic [61:0] remx;
  div_t        dv_d, dv_q;

  always_comb begin
    dv_d = dv_i;
    dsh  = {30'd0, dv_i.r} << K;
    remx = '0;
    for (int l = 0; l < 3; l++) begin
      remx = {2'b00, dv_i.rem[l]};
      if (remx >= dsh) begin
        dv_d.rem[l]  = 60'(remx - dsh);
        dv_d.q[l][K] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dv_q <= dv_d;
  end

  assign dv_o = dv_q;

endmodule

`default_nettype wire

// File: test/axis_angle_rotation_matrix_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix_checker
// Watches the request and result channels, predicts each rotation matrix
// with a bit-exact fixed-point Rodrigues model and compares field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module axis_angle_rotation_matrix_checker #(
  parameter int unsigned OUT_FRAC_BITS = 14
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic            busy_i,
  input  wire aarm_pkg::req_t  req_i,
  input  wire logic            done_i,
  input  wire aarm_pkg::res_t  res_i,
  output int                   fail_count_o,
  output int                   pending_o
);
  import aarm_pkg::*;

  localparam longint ONE30 = 64'sd1073741824;

  res_t matrix_q[$];

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rnd_shr(longint v, int s);
    if (s == 0) return v;
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_to(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic logic [15:0] fix_out(longint v);
    longint o;
    o = clamp_to(rnd_shr(v, 30 - OUT_FRAC_BITS), 64'sd1 <<< OUT_FRAC_BITS);
    return o[15:0];
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned acc, bitv;
    acc = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= acc + bitv) begin
        n -= acc + bitv;
        acc = (acc >> 1) + bitv;
      end else begin
        acc >>= 1;
      end
      bitv >>= 2;
    end
    return acc;
  endfunction

  function automatic longint arctan_q30(int i);
    longint tab[24];
    tab = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
            16775850, 8388437, 4194282, 2097149, 1048575, 524287,
            262143, 131071, 65535, 32767, 16383, 8191,
            4095, 2047, 1023, 511, 255, 127};
    return tab[i];
  endfunction

  function automatic res_t rotation_of(req_t rq);
    res_t m;
    longint v[3], u[3];
    longint unsigned sq, r, mag;
    longint th, cx, cy, dx, dy, c, s, oc, q;
    longint xx, yy, zz, xy, yz, zx, xs, ys, zs;
    bit flip;
    m = '0;
    flip = 0;
    v[0] = rq.axis_x; v[1] = rq.axis_y; v[2] = rq.axis_z;
    sq = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
    if (sq == 0) begin
      m.c0_r0 = 16'(64'sd1 <<< OUT_FRAC_BITS);
      m.c1_r1 = m.c0_r0;
      m.c2_r2 = m.c0_r0;
      m.zero_axis = 1'b1;
      return m;
    end
    r = int_sqrt(sq << 28);
    for (int i = 0; i < 3; i++) begin
      mag = longint'(v[i] < 0 ? -v[i] : v[i]) << 44;
      q = longint'(mag / r);
      if (q > ONE30) q = ONE30;
      u[i] = v[i] < 0 ? -q : q;
    end
    th = longint'(rq.angle) * 131072;
    if (th > 64'sd1686629713) begin
      th -= 64'sd3373259426; flip = 1;
    end else if (th < -64'sd1686629713) begin
      th += 64'sd3373259426; flip = 1;
    end
    cx = 64'sd652032874;
    cy = 0;
    for (int i = 0; i < 24; i++) begin
      dx = floor_shr(cy, i);
      dy = floor_shr(cx, i);
      if (th >= 0) begin
        cx -= dx; cy += dy; th -= arctan_q30(i);
      end else begin
        cx += dx; cy -= dy; th += arctan_q30(i);
      end
    end
    if (flip) begin
      cx = -cx; cy = -cy;
    end
    c = clamp_to(cx, ONE30);
    s = clamp_to(cy, ONE30);
    oc = ONE30 - c;
    xx = rnd_shr(oc * rnd_shr(u[0] * u[0], 30), 30);
    yy = rnd_shr(oc * rnd_shr(u[1] * u[1], 30), 30);
    zz = rnd_shr(oc * rnd_shr(u[2] * u[2], 30), 30);
    xy = rnd_shr(oc * rnd_shr(u[0] * u[1], 30), 30);
    yz = rnd_shr(oc * rnd_shr(u[1] * u[2], 30), 30);
    zx = rnd_shr(oc * rnd_shr(u[2] * u[0], 30), 30);
    xs = rnd_shr(u[0] * s, 30);
    ys = rnd_shr(u[1] * s, 30);
    zs = rnd_shr(u[2] * s, 30);
    m.c0_r0 = fix_out(xx + c);
    m.c0_r1 = fix_out(xy - zs);
    m.c0_r2 = fix_out(zx + ys);
    m.c1_r0 = fix_out(xy + zs);
    m.c1_r1 = fix_out(yy + c);
    m.c1_r2 = fix_out(yz - xs);
    m.c2_r0 = fix_out(zx - ys);
    m.c2_r1 = fix_out(yz + xs);
    m.c2_r2 = fix_out(zz + c);
    return m;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    fail_count_o++;
  endtask

  task automatic compare_matrix(res_t got, res_t want);
    if (got.c0_r0 !== want.c0_r0) report_mismatch("c0_r0", got.c0_r0, want.c0_r0);
    if (got.c0_r1 !== want.c0_r1) report_mismatch("c0_r1", got.c0_r1, want.c0_r1);
    if (got.c0_r2 !== want.c0_r2) report_mismatch("c0_r2", got.c0_r2, want.c0_r2);
    if (got.c1_r0 !== want.c1_r0) report_mismatch("c1_r0", got.c1_r0, want.c1_r0);
    if (got.c1_r1 !== want.c1_r1) report_mismatch("c1_r1", got.c1_r1, want.c1_r1);
    if (got.c1_r2 !== want.c1_r2) report_mismatch("c1_r2", got.c1_r2, want.c1_r2);
    if (got.c2_r0 !== want.c2_r0) report_mismatch("c2_r0", got.c2_r0, want.c2_r0);
    if (got.c2_r1 !== want.c2_r1) report_mismatch("c2_r1", got.c2_r1, want.c2_r1);
    if (got.c2_r2 !== want.c2_r2) report_mismatch("c2_r2", got.c2_r2, want.c2_r2);
    if (got.zero_axis !== want.zero_axis)
      report_mismatch("zero_axis", got.zero_axis, want.zero_axis);
  endtask

  initial fail_count_o = 0;
  assign pending_o = matrix_q.size();

  always @(posedge clk_i) begin
    if (rst_ni) begin
      // compare before queuing: a result cannot belong to this edge's request
      if (done_i === 1'b1) begin
        if (matrix_q.size() == 0) begin
          $display("%0t result with no request outstanding", $realtime);
          fail_count_o++;
        end else begin
          compare_matrix(res_i, matrix_q.pop_front());
        end
      end
      if (start_i && busy_i === 1'b0) matrix_q.push_back(rotation_of(req_i));
    end
  end

endmodule

`default_nettype wire

// File: test/axis_angle_rotation_matrix_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix_tb
// Drives directed and random axis/angle requests in bursts and gives the
// verdict from the checker's failure count.
// ----------------------------------------------------------------------------
`default_nettype none

module axis_angle_rotation_matrix_tb;
  import aarm_pkg::*;

  localparam int N_RANDOM = 1700;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o, done_o;
  req_t req_i = '0;
  res_t res_o;
  int   fail_count, pending;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  axis_angle_rotation_matrix u_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .req_i, .done_o, .res_o
  );

  axis_angle_rotation_matrix_checker u_chk (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .req_i, .done_i(done_o),
    .res_i(res_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  int gap_left = 0;
  int burst_left = 0;

  // hold the request until taken; idle between most bursts
  task automatic send_request(req_t rq);
    while (burst_left == 0) begin
      if (gap_left > 0) begin
        start_i <= 1'b0;
        @(negedge clk_i);
        gap_left--;
      end else begin
        burst_left = $urandom_range(1, 40);
      end
    end
    start_i <= 1'b1;
    req_i   <= rq;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    @(negedge clk_i);
    burst_left--;
    if (burst_left == 0) gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
  endtask

  function automatic logic signed [15:0] axis_value();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'($urandom_range(0, 6)) - 16'sd3;
      3: return 16'sd0;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    req_t rq;
    logic signed [15:0] ext[6];
    ext = '{16'sh8000, 16'sh7fff, 16'sd0, 16'sd1, -16'sd1, 16'sd12868};
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // zero axis, single-axis extremes and angle extremes incl. the half-turn fold at +/- pi/2
    foreach (ext[a]) begin
      rq = '{axis_x: ext[a], axis_y: ext[(a + 1) % 6], axis_z: ext[(a + 2) % 6],
             angle: ext[(a + 3) % 6]};
      send_request(rq);
    end
    send_request('{16'sd0, 16'sd0, 16'sd0, 16'sd5000});
    send_request('{16'sd1, 16'sd0, 16'sd0, 16'sd12868});
    send_request('{16'sd0, -16'sd1, 16'sd0, -16'sd12869});
    send_request('{16'sd0, 16'sd0, 16'sh7fff, 16'sh8000});
    send_request('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff});
    send_request('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sd0});
    send_request('{16'sd3, 16'sd4, 16'sd0, 16'sd25736});
    for (int i = 0; i < N_RANDOM; i++) begin
      rq.axis_x = axis_value();
      rq.axis_y = axis_value();
      rq.axis_z = axis_value();
      rq.angle  = ($urandom_range(0, 7) == 0) ? axis_value() : 16'($urandom);
      send_request(rq);
    end
    start_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS axis_angle_rotation_matrix");
    end else begin
      $display("FAIL axis_angle_rotation_matrix");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("FAIL axis_angle_rotation_matrix");
    $finish;
  end

endmodule

`default_nettype wire

// File: axis_angle_rotation_matrix.f
rtl/aarm_pkg.sv
rtl/aarm_sqrt_cell.sv
rtl/aarm_cordic_cell.sv
rtl/aarm_div_cell.sv
rtl/axis_angle_rotation_matrix.sv
test/axis_angle_rotation_matrix_checker.sv
test/axis_angle_rotation_matrix_tb.sv
